// File: hdl/jsu_pkg.sv
// shared types and constants of the json string unescape block
`default_nettype none
package jsu_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       last;
	} out_item_t;

	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_CLOSED = 2'd1;
	localparam logic [1:0] KIND_NONE   = 2'd2;
	localparam logic [1:0] KIND_ENDED  = 2'd3;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_STR,
		MODE_ESC,
		MODE_HEX
	} mode_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_BYTE,
		OP_CP,
		OP_CLOSED,
		OP_NOSTR
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] data;
		logic        ended;
	} op_entry_t;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF8_CONT  = 8'h80;
	localparam logic [5:0]  UTF8_MASK  = 6'h3F;
	localparam logic [15:0] CP_ONE     = 16'h0080;
	localparam logic [15:0] CP_TWO     = 16'h0800;

endpackage
`default_nettype wire

// File: hdl/jsu_front.sv
// front end: string state machine classifying bytes; bytes with results push entries
`default_nettype none
module jsu_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire jsu_pkg::in_item_t  item,
	output logic                    push,
	output jsu_pkg::op_entry_t      entry
);
	import jsu_pkg::*;

	mode_t       mode_q, mode_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [15:0] cp_q, cp_d;
	logic [7:0]  b;
	logic        fin;
	logic [15:0] cp_shift;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = 4'(c[3:0] + 4'd9);
		end
		return v;
	endfunction

	function automatic logic [7:0] escape_map(input logic [7:0] e);
		logic [7:0] r;
		unique case (e)
			8'h6E:   r = 8'h0A;
			8'h74:   r = 8'h09;
			8'h72:   r = 8'h0D;
			8'h62:   r = 8'h08;
			8'h66:   r = 8'h0C;
			default: r = e;
		endcase
		return r;
	endfunction

	assign b        = item.data_byte;
	assign fin      = item.final_byte;
	assign cp_shift = {cp_q[11:0], hex_value(b)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			hex_cnt_q <= 2'd0;
			cp_q      <= 16'd0;
		end else if (accept) begin
			mode_q    <= mode_d;
			hex_cnt_q <= hex_cnt_d;
			cp_q      <= cp_d;
		end
	end

	always_comb begin
		mode_d      = mode_q;
		hex_cnt_d   = hex_cnt_q;
		cp_d        = cp_q;
		entry.op    = OP_NONE;
		entry.data  = 16'd0;
		entry.ended = 1'b0;
		unique case (mode_q)
			MODE_IDLE: begin
				if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
					entry.ended = fin;
				end else if (b == CH_QUOTE) begin
					entry.ended = fin;
					if (!fin) begin
						mode_d = MODE_STR;
					end
				end else begin
					entry.op = OP_NOSTR;
				end
			end
			MODE_STR: begin
				if (b == CH_QUOTE) begin
					entry.op = OP_CLOSED;
					mode_d   = MODE_IDLE;
				end else if (b == CH_BSLASH && !fin) begin
					mode_d = MODE_ESC;
				end else begin
					entry.op    = OP_BYTE;
					entry.data  = {8'd0, b};
					entry.ended = fin;
				end
			end
			MODE_ESC: begin
				if (b == CH_U) begin
					mode_d    = MODE_HEX;
					hex_cnt_d = 2'd0;
					cp_d      = 16'd0;
				end else begin
					entry.op   = OP_BYTE;
					entry.data = {8'd0, escape_map(b)};
					mode_d     = MODE_STR;
				end
				entry.ended = fin;
			end
			MODE_HEX: begin
				if (hex_cnt_q == 2'd3) begin
					entry.op   = OP_CP;
					entry.data = cp_shift;
					mode_d     = MODE_STR;
					hex_cnt_d  = 2'd0;
					cp_d       = 16'd0;
				end else begin
					hex_cnt_d = 2'(hex_cnt_q + 2'd1);
					cp_d      = cp_shift;
				end
				entry.ended = fin;
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase
		if (entry.ended) begin
			mode_d    = MODE_IDLE;
			hex_cnt_d = 2'd0;
			cp_d      = 16'd0;
		end
		push = accept && (entry.op != OP_NONE || entry.ended);
	end

	a_final_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && fin |=> mode_q == MODE_IDLE && hex_cnt_q == 2'd0 && cp_q == 16'd0)
		else $error("final byte did not return the front end to idle");

	a_hex_only_in_hex: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_HEX |-> hex_cnt_q == 2'd0)
		else $error("hex digit count set outside a unicode escape");

endmodule
`default_nettype wire

// File: hdl/jsu_queue.sv
// short queue of classified entries between front and back
`default_nettype none
module jsu_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire jsu_pkg::op_entry_t  wr_entry,
	input  wire logic                pop,
	output jsu_pkg::op_entry_t       head,
	output logic                     not_empty,
	output logic                     full
);
	import jsu_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_entry_t      store_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign not_empty = count_q != '0;
	assign full      = count_q == CW'(DEPTH);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = store_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("entry pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

// File: hdl/jsu_back.sv
// back end: expands queue entries into result items, one per cycle while res_stall is low
`default_nettype none
module jsu_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire jsu_pkg::op_entry_t  head,
	input  wire logic                head_valid,
	output logic                     pop,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output jsu_pkg::out_item_t       res_item
);
	import jsu_pkg::*;

	logic [1:0] idx_q;
	logic       res_valid_q;
	out_item_t  res_q;
	logic       load;
	logic [1:0] n_data;
	logic       tail;
	logic [2:0] total;
	logic       step_last;
	out_item_t  step;
	logic [15:0] cp;

	assign cp = head.data;

	always_comb begin
		n_data = 2'd0;
		tail   = head.ended;
		case (head.op)
			OP_BYTE: n_data = 2'd1;
			OP_CP: begin
				if (cp < CP_ONE) begin
					n_data = 2'd1;
				end else if (cp < CP_TWO) begin
					n_data = 2'd2;
				end else begin
					n_data = 2'd3;
				end
			end
			OP_CLOSED, OP_NOSTR: tail = 1'b1;
			default: n_data = 2'd0;
		endcase
		total     = 3'(n_data) + 3'(tail);
		step_last = (3'(idx_q) + 3'd1) == total;

		step.out_byte = 8'd0;
		step.kind     = KIND_ENDED;
		step.last     = step_last;
		if (idx_q < n_data) begin
			step.kind = KIND_BYTE;
			if (head.op == OP_BYTE || n_data == 2'd1) begin
				step.out_byte = cp[7:0];
			end else if (n_data == 2'd2) begin
				step.out_byte = (idx_q == 2'd0) ? (UTF8_LEAD2 | {3'd0, cp[10:6]})
				                                : (UTF8_CONT | {2'd0, cp[5:0] & UTF8_MASK});
			end else begin
				case (idx_q)
					2'd0:    step.out_byte = UTF8_LEAD3 | {4'd0, cp[15:12]};
					2'd1:    step.out_byte = UTF8_CONT | {2'd0, cp[11:6] & UTF8_MASK};
					default: step.out_byte = UTF8_CONT | {2'd0, cp[5:0] & UTF8_MASK};
				endcase
			end
		end else if (head.op == OP_CLOSED) begin
			step.kind = KIND_CLOSED;
		end else if (head.op == OP_NOSTR) begin
			step.kind = KIND_NONE;
		end
	end

	assign load = !res_valid_q || !res_stall;
	assign pop  = load && head_valid && step_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (load) begin
			res_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= step_last ? 2'd0 : 2'(idx_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			res_q <= step;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res_item.last |=> res_valid)
		else $error("result sequence broken before its last item");

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.kind != KIND_BYTE |-> res_item.last)
		else $error("end marker not flagged as last");

endmodule
`default_nettype wire

// File: hdl/json_string_unescape_utf8_core.sv
// top level of the json string unescape block with utf-8 output
//
// input channel byte_*: one raw json text byte per request, with a flag for the
// final byte of the buffer. output channel res_*: decoded string bytes and end
// markers (closed by quote, no string found, input ended), last set on the final
// result that one input byte causes; an input byte gives zero to four results.
// both channels use valid and stall; a request moves when valid is high and
// stall is low.
// a front end runs the string state machine and classifies every byte; a byte with
// results pushes an entry into a QDEPTH-deep queue; a back end expands one entry
// into its results and places one result a cycle in the output register while
// res_stall does not hold it. the first result of a byte passes through the queue
// and the output register. throughput: one byte a cycle while res_stall is low and
// each byte gives at most one result; a \u escape yields up to three utf-8 bytes
// plus a marker, one per cycle, and the queue absorbs the extra cycles until it fills.
// byte_stall is high only while the queue is full, which happens when res_stall
// holds the output register or results outpace bytes.
// reset clears the state machine to idle and empties queue and output register.
`default_nettype none
module json_string_unescape_utf8_core #(
	parameter int QDEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_stall,
	input  wire jsu_pkg::in_item_t   byte_item,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output jsu_pkg::out_item_t       res_item
);
	import jsu_pkg::*;

	logic      accept;
	logic      push;
	op_entry_t entry;
	op_entry_t head;
	logic      head_valid;
	logic      pop;
	logic      q_full;

	assign byte_stall = q_full;
	assign accept     = byte_valid && !q_full;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (byte_item),
		.push   (push),
		.entry  (entry)
	);

	jsu_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (entry),
		.pop       (pop),
		.head      (head),
		.not_empty (head_valid),
		.full      (q_full)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item)
	);

endmodule
`default_nettype wire

// File: tb/tb_json_string_unescape_utf8_core.sv
// testbench for the json string unescape block: directed and random text checked against a byte model
`timescale 1ns / 1ps
module tb_json_string_unescape_utf8_core;
	import jsu_pkg::*;

	localparam logic [7:0] WS_CHARS [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
	localparam logic [7:0] ESC_CHARS [8] = '{"n", "t", "r", "b", "f", "\"", "\\", "/"};

	class unescape_tracker;
		out_item_t decoded[$];
		mode_t mode;
		logic [1:0] hex_seen;
		logic [15:0] code_point;
		int errors;

		function new();
			mode = MODE_IDLE;
			hex_seen = '0;
			code_point = '0;
			errors = 0;
		endfunction

		function void add_result(logic [7:0] b, logic [1:0] k);
			out_item_t r;
			r.out_byte = b;
			r.kind = k;
			r.last = 1'b0;
			decoded.insert(decoded.size(), r);
		endfunction

		function void take_byte(in_item_t req);
			int n_old;
			logic [7:0] b;
			logic [7:0] mapped;
			logic [3:0] digit;
			logic [15:0] cp;
			bit ended;
			n_old = decoded.size();
			b = req.data_byte;
			ended = 1'b0;
			case (mode)
			MODE_IDLE: begin
				if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
					ended = req.final_byte;
				end else if (b == CH_QUOTE) begin
					if (req.final_byte)
						ended = 1'b1;
					else
						mode = MODE_STR;
				end else begin
					add_result(8'h00, KIND_NONE);
				end
			end
			MODE_STR: begin
				if (b == CH_QUOTE) begin
					add_result(8'h00, KIND_CLOSED);
					mode = MODE_IDLE;
					hex_seen = '0;
					code_point = '0;
				end else if (b == CH_BSLASH && !req.final_byte) begin
					mode = MODE_ESC;
				end else begin
					add_result(b, KIND_BYTE);
					ended = req.final_byte;
				end
			end
			MODE_ESC: begin
				if (b == CH_U) begin
					mode = MODE_HEX;
					hex_seen = '0;
					code_point = '0;
				end else begin
					case (b)
					"n": mapped = 8'h0a;
					"t": mapped = 8'h09;
					"r": mapped = 8'h0d;
					"b": mapped = 8'h08;
					"f": mapped = 8'h0c;
					default: mapped = b;
					endcase
					add_result(mapped, KIND_BYTE);
					mode = MODE_STR;
				end
				ended = req.final_byte;
			end
			default: begin
				// anything that is not a hex digit counts as zero
				if (b >= "0" && b <= "9")
					digit = b[3:0];
				else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
					digit = b[3:0] + 4'd9;
				else
					digit = 4'h0;
				cp = {code_point[11:0], digit};
				if (hex_seen == 2'd3) begin
					if (cp < CP_ONE) begin
						add_result(cp[7:0], KIND_BYTE);
					end else if (cp < CP_TWO) begin
						add_result(UTF8_LEAD2 | {3'b000, cp[10:6]}, KIND_BYTE);
						add_result(UTF8_CONT | {2'b00, cp[5:0]}, KIND_BYTE);
					end else begin
						add_result(UTF8_LEAD3 | {4'h0, cp[15:12]}, KIND_BYTE);
						add_result(UTF8_CONT | {2'b00, cp[11:6]}, KIND_BYTE);
						add_result(UTF8_CONT | {2'b00, cp[5:0]}, KIND_BYTE);
					end
					mode = MODE_STR;
					hex_seen = '0;
					code_point = '0;
				end else begin
					hex_seen = hex_seen + 2'd1;
					code_point = cp;
				end
				ended = req.final_byte;
			end
			endcase
			if (ended) begin
				add_result(8'h00, KIND_ENDED);
				mode = MODE_IDLE;
				hex_seen = '0;
				code_point = '0;
			end
			if (decoded.size() > n_old)
				decoded[decoded.size() - 1].last = 1'b1;
		endfunction

		function void match_result(out_item_t got);
			out_item_t want;
			if (decoded.size() == 0) begin
				$error("result with nothing outstanding: out_byte %02h kind %0d last %0d",
					got.out_byte, got.kind, got.last);
				errors++;
				return;
			end
			want = decoded.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	in_item_t byte_item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	out_item_t res_item;

	int idle_pct = 27;
	int sent = 0;
	bit drained = 1'b0;
	unescape_tracker tracker = new();

	json_string_unescape_utf8_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (res_valid && !res_stall)
			tracker.match_result(res_item);
		res_stall <= ($urandom_range(0, 99) < idle_pct);
	end

	task automatic send_byte(input logic [7:0] b, input bit fin);
		in_item_t req;
		req.data_byte = b;
		req.final_byte = fin;
		while ($urandom_range(0, 99) < idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= req;
		do @(posedge clk); while (byte_stall);
		tracker.take_byte(req);
		sent++;
	endtask

	task automatic send_text(input string s, input bit fin);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], fin && i == s.len() - 1);
	endtask

	task automatic send_random_string();
		logic [7:0] text[$];
		logic [7:0] b;
		logic [15:0] cp;
		logic [3:0] nib;
		int k;
		bit fin;
		repeat ($urandom_range(0, 2))
			text.insert(text.size(), WS_CHARS[$urandom_range(0, 3)]);
		text.insert(text.size(), CH_QUOTE);
		repeat ($urandom_range(0, 8)) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				b = 8'($urandom_range(0, 255));
				while (b == CH_QUOTE || b == CH_BSLASH)
					b = 8'($urandom_range(0, 255));
				text.insert(text.size(), b);
			end
			5, 6: begin
				text.insert(text.size(), CH_BSLASH);
				if ($urandom_range(0, 3) == 0) begin
					b = 8'($urandom_range(0, 255));
					while (b == CH_U)
						b = 8'($urandom_range(0, 255));
					text.insert(text.size(), b);
				end else begin
					text.insert(text.size(), ESC_CHARS[$urandom_range(0, 7)]);
				end
			end
			default: begin
				text.insert(text.size(), CH_BSLASH);
				text.insert(text.size(), CH_U);
				case ($urandom_range(0, 3))
				0: cp = 16'($urandom_range(0, 16'h007f));
				1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
				2: cp = 16'($urandom_range(16'h0800, 16'hffff));
				default: cp = 16'($urandom_range(0, 16'hffff));
				endcase
				for (int d = 3; d >= 0; d--) begin
					nib = cp[d * 4 +: 4];
					if ($urandom_range(0, 11) == 0)
						b = 8'($urandom_range(0, 255));
					else if (nib < 4'd10)
						b = 8'h30 + {4'h0, nib};
					else
						b = ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, nib} - 8'd10;
					text.insert(text.size(), b);
				end
			end
			endcase
		end
		k = $urandom_range(0, 9);
		if (k < 7) begin
			text.insert(text.size(), CH_QUOTE);
			fin = ($urandom_range(0, 3) == 0);
		end else begin
			fin = 1'b1;
			if (k == 9) begin
				k = $urandom_range(0, text.size() - 1);
				while (text.size() > k + 1)
					void'(text.pop_back());
			end
		end
		for (int i = 0; i < text.size(); i++)
			send_byte(text[i], fin && i == text.size() - 1);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_byte(8'hff, 1'b0);
		send_byte(CH_SPACE, 1'b1);
		send_byte(CH_QUOTE, 1'b1);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_text("\\uFfFF\\u07z\"\\/", 1'b0);
		send_text("\\", 1'b1);
		send_text("\"\\u1", 1'b1);
		send_text("\"x\"", 1'b1);

		while (sent < 330) begin
			idle_pct = (sent >= 150 && sent < 230) ? 0 : 27;
			if (!drained && sent >= 100) begin
				byte_valid <= 1'b0;
				@(posedge clk);
				while (tracker.decoded.size() != 0)
					@(posedge clk);
				drained = 1'b1;
			end
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end else begin
				send_random_string();
			end
		end
		byte_valid <= 1'b0;

		while (tracker.decoded.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.decoded.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

// File: json_string_unescape_utf8_core.f
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8_core.sv
tb/tb_json_string_unescape_utf8_core.sv
